// ===== rtl/bgr_to_hsv_range_mask_top_macros.svh =====
// assertion macros for the bgr to hsv range mask block
// no dependencies; included by the top level
`ifndef BGR_TO_HSV_RANGE_MASK_TOP_MACROS_SVH
`define BGR_TO_HSV_RANGE_MASK_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define BHRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bhrm assertion failed");

// next-cycle implication, checked out of reset
`define BHRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bhrm assertion failed");

`else

`define BHRM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BHRM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bhrm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the divider step for the bgr to hsv range mask block
// no dependencies
package bhrm_pkg;

	localparam int DivSteps  = 8;
	// convert, numerators, divider steps, mask/output
	localparam int NumStages = DivSteps + 3;

	typedef enum logic [2:0] {
		RegHueLow  = 3'd0,
		RegHueHigh = 3'd1,
		RegSatLow  = 3'd2,
		RegSatHigh = 3'd3,
		RegValLow  = 3'd4,
		RegValHigh = 3'd5
	} reg_idx_t;

	localparam logic [7:0] HueLowReset  = 8'd0;
	localparam logic [7:0] HueHighReset = 8'd180;
	localparam logic [7:0] SatLowReset  = 8'd0;
	localparam logic [7:0] SatHighReset = 8'd255;
	localparam logic [7:0] ValLowReset  = 8'd0;
	localparam logic [7:0] ValHighReset = 8'd255;

	// hue offset in degrees, as a multiple of delta
	typedef enum logic [1:0] {
		BaseZero = 2'd0,
		Base120  = 2'd1,
		Base240  = 2'd2,
		Base360  = 2'd3
	} hue_base_t;

	// both restoring divisions travel side by side
	typedef struct packed {
		logic [7:0] srem;
		logic [7:0] slo;
		logic [7:0] sdiv;
		logic [7:0] sq;
		logic [8:0] hrem;
		logic [7:0] hlo;
		logic [8:0] hdiv;
		logic [7:0] hq;
		logic [7:0] val;
	} div_word_t;

	// one quotient bit of each division
	function automatic div_word_t div_step(div_word_t d);
		logic [8:0] st;
		logic [9:0] ht;
		div_word_t r;
		r = d;
		st = {d.srem, d.slo[7]};
		ht = {d.hrem, d.hlo[7]};
		r.slo = {d.slo[6:0], 1'b0};
		r.hlo = {d.hlo[6:0], 1'b0};
		if (st >= {1'b0, d.sdiv}) begin
			r.srem = 8'(st - {1'b0, d.sdiv});
			r.sq = {d.sq[6:0], 1'b1};
		end else begin
			r.srem = st[7:0];
			r.sq = {d.sq[6:0], 1'b0};
		end
		if (ht >= {1'b0, d.hdiv}) begin
			r.hrem = 9'(ht - {1'b0, d.hdiv});
			r.hq = {d.hq[6:0], 1'b1};
		end else begin
			r.hrem = ht[8:0];
			r.hq = {d.hq[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== rtl/bgr_to_hsv_range_mask_top.sv =====
`timescale 1ns / 1ps
// bgr pixel to half-scale hsv with an inclusive hsv range mask, apb register port
// depends on bhrm_pkg and bgr_to_hsv_range_mask_top_macros.svh
// pipeline: eleven register stages (convert, numerators, eight restoring divider stages,
//   mask/output register)
// throughput: one pixel per cycle; each stage stalls only when it is full and the
//   one after it cannot take its data, so bubbles are squeezed out
// reset: arst_n clears all stage valid bits and loads the range registers to
//   hue 0..180, saturation 0..255, brightness 0..255
module bgr_to_hsv_range_mask_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [7:0] brightness,
	output logic       in_mask,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	localparam int NumStages = bhrm_pkg::NumStages;
	localparam int DivSteps  = bhrm_pkg::DivSteps;

	// range registers
	logic [7:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q, val_low_q, val_high_q;
	logic       cfg_wr;
	bhrm_pkg::reg_idx_t cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = bhrm_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q <= bhrm_pkg::HueLowReset;
			hue_high_q <= bhrm_pkg::HueHighReset;
			sat_low_q <= bhrm_pkg::SatLowReset;
			sat_high_q <= bhrm_pkg::SatHighReset;
			val_low_q <= bhrm_pkg::ValLowReset;
			val_high_q <= bhrm_pkg::ValHighReset;
		end else if (cfg_wr) begin
			case (cfg_idx)
				bhrm_pkg::RegHueLow: hue_low_q <= pwdata[7:0];
				bhrm_pkg::RegHueHigh: hue_high_q <= pwdata[7:0];
				bhrm_pkg::RegSatLow: sat_low_q <= pwdata[7:0];
				bhrm_pkg::RegSatHigh: sat_high_q <= pwdata[7:0];
				bhrm_pkg::RegValLow: val_low_q <= pwdata[7:0];
				bhrm_pkg::RegValHigh: val_high_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			bhrm_pkg::RegHueLow: prdata = {24'd0, hue_low_q};
			bhrm_pkg::RegHueHigh: prdata = {24'd0, hue_high_q};
			bhrm_pkg::RegSatLow: prdata = {24'd0, sat_low_q};
			bhrm_pkg::RegSatHigh: prdata = {24'd0, sat_high_q};
			bhrm_pkg::RegValLow: prdata = {24'd0, val_low_q};
			bhrm_pkg::RegValHigh: prdata = {24'd0, val_high_q};
			default: prdata = 32'd0;
		endcase
	end

	// pipeline control: bit i is the valid of stage i+1
	logic [NumStages-1:0] vld_q;
	logic [NumStages:0]   rdy;
	logic [NumStages-1:0] vin;
	logic [NumStages-1:0] ld;

	assign vin = {vld_q[NumStages-2:0], in_valid};

	always_comb begin
		rdy[NumStages] = out_ready;
		for (int i = NumStages - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign ld = rdy[NumStages-1:0] & vin;
	assign in_ready = rdy[0];
	assign out_valid = vld_q[NumStages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NumStages; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	// stage 1: max, min, delta, hue sector and signed channel difference
	logic [7:0] mx, mn;
	logic signed [8:0] sd;
	bhrm_pkg::hue_base_t base;

	always_comb begin
		mx = (green >= blue) ? green : blue;
		if (red >= mx) begin
			mx = red;
		end
		mn = (green < blue) ? green : blue;
		if (red < mn) begin
			mn = red;
		end
		// ties: red wins over green, green over blue
		if (red == mx) begin
			sd = $signed({1'b0, green}) - $signed({1'b0, blue});
			base = (green >= blue) ? bhrm_pkg::BaseZero : bhrm_pkg::Base360;
		end else if (green == mx) begin
			sd = $signed({1'b0, blue}) - $signed({1'b0, red});
			base = bhrm_pkg::Base120;
		end else begin
			sd = $signed({1'b0, red}) - $signed({1'b0, green});
			base = bhrm_pkg::Base240;
		end
	end

	logic [7:0] mx_s1, dl_s1;
	logic signed [8:0] sd_s1;
	bhrm_pkg::hue_base_t base_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			mx_s1 <= mx;
			dl_s1 <= mx - mn;
			sd_s1 <= sd;
			base_s1 <= base;
		end
	end

	// stage 2: dividends and divisors; grey or black pixels divide 0 by 1
	logic [16:0] base_mul;
	logic signed [17:0] sd_ext, hue_num_full;
	logic [15:0] sat_num;
	logic [16:0] hue_num;
	bhrm_pkg::div_word_t dv_init;

	always_comb begin
		case (base_s1)
			bhrm_pkg::BaseZero: base_mul = 17'd0;
			bhrm_pkg::Base120: base_mul = ({9'd0, dl_s1} << 7) - ({9'd0, dl_s1} << 3);
			bhrm_pkg::Base240: base_mul = ({9'd0, dl_s1} << 8) - ({9'd0, dl_s1} << 4);
			bhrm_pkg::Base360: base_mul = ({9'd0, dl_s1} << 8) + ({9'd0, dl_s1} << 6)
				+ ({9'd0, dl_s1} << 5) + ({9'd0, dl_s1} << 3);
			default: base_mul = 17'd0;
		endcase
		sd_ext = 18'(sd_s1);
		// 60 * diff as 64 - 4
		hue_num_full = $signed({1'b0, base_mul}) + (sd_ext <<< 6) - (sd_ext <<< 2);
		sat_num = {dl_s1, 8'd0} - {8'd0, dl_s1};
		hue_num = hue_num_full[16:0];

		dv_init.sq = 8'd0;
		dv_init.hq = 8'd0;
		dv_init.val = mx_s1;
		if (dl_s1 == 8'd0) begin
			dv_init.srem = 8'd0;
			dv_init.slo = 8'd0;
			dv_init.sdiv = 8'd1;
			dv_init.hrem = 9'd0;
			dv_init.hlo = 8'd0;
			dv_init.hdiv = 9'd1;
		end else begin
			// upper dividend bits already sit below the divisor
			dv_init.srem = sat_num[15:8];
			dv_init.slo = sat_num[7:0];
			dv_init.sdiv = mx_s1;
			dv_init.hrem = hue_num[16:8];
			dv_init.hlo = hue_num[7:0];
			dv_init.hdiv = {dl_s1, 1'b0};
		end
	end

	// dv_s[0] is stage 2, dv_s[k] is divider stage k (pipeline stage k+2)
	bhrm_pkg::div_word_t dv_s [DivSteps+1];

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dv_s[0] <= dv_init;
		end
	end

	for (genvar k = 1; k <= DivSteps; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (ld[k+1]) begin
				dv_s[k] <= bhrm_pkg::div_step(dv_s[k-1]);
			end
		end
	end

	// last stage: range compare and output register
	logic [7:0] h_fin, s_fin, v_fin;
	logic hue_ok, in_range;

	always_comb begin
		h_fin = dv_s[DivSteps].hq;
		s_fin = dv_s[DivSteps].sq;
		v_fin = dv_s[DivSteps].val;
		if (hue_high_q >= hue_low_q) begin
			hue_ok = (h_fin >= hue_low_q) && (h_fin <= hue_high_q);
		end else begin
			// wrapped range
			hue_ok = (h_fin >= hue_low_q) || (h_fin <= hue_high_q);
		end
		in_range = hue_ok && (s_fin >= sat_low_q) && (s_fin <= sat_high_q)
			&& (v_fin >= val_low_q) && (v_fin <= val_high_q);
	end

	logic [7:0] hue_s11, sat_s11, val_s11;
	logic       mask_s11;

	always_ff @(posedge clk) begin
		if (ld[NumStages-1]) begin
			hue_s11 <= h_fin;
			sat_s11 <= s_fin;
			val_s11 <= v_fin;
			mask_s11 <= in_range;
		end
	end

	assign hue = hue_s11;
	assign saturation = sat_s11;
	assign brightness = val_s11;
	assign in_mask = mask_s11;

`include "bgr_to_hsv_range_mask_top_macros.svh"

	`BHRM_ASSERT_IMP(a_hue_range, clk, arst_n, out_valid, hue < 8'd180)
	`BHRM_ASSERT_IMP(a_black_zero, clk, arst_n, out_valid && brightness == 8'd0,
		saturation == 8'd0 && hue == 8'd0)
	`BHRM_ASSERT_IMP(a_stall_full, clk, arst_n, !in_ready, &vld_q)
	`BHRM_ASSERT_IMP(a_div_rem, clk, arst_n, vld_q[NumStages-2],
		dv_s[DivSteps].srem < dv_s[DivSteps].sdiv && dv_s[DivSteps].hrem < dv_s[DivSteps].hdiv)
	`BHRM_ASSERT_NXT(a_out_fill, clk, arst_n, vld_q[NumStages-2] && rdy[NumStages-1], out_valid)

endmodule
